// ===== src/hemisphere_direction_sampler_unit_defines.svh =====
// ---------------------------------------------------------------------------
// Hemisphere direction sampler: assertion macros
// Shared property forms for the checker. The clock is clk and the
// synchronous reset is rst in every scope that uses these.
// ---------------------------------------------------------------------------
`ifndef HEMISPHERE_DIRECTION_SAMPLER_UNIT_DEFINES_SVH
`define HEMISPHERE_DIRECTION_SAMPLER_UNIT_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define HDS_ASSERT_IMPLY(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("hemisphere sampler check failed (same-cycle implication)");

// Next-cycle implication, checked outside reset.
`define HDS_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("hemisphere sampler check failed (next-cycle implication)");

`endif

// ===== src/hds_pkg.sv =====
// ---------------------------------------------------------------------------
// Hemisphere direction sampler package
// Fixed-point types, pipeline depths and constant tables.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package hds_pkg;

  // Signed Q.30 working word with headroom for sums and rotations
  localparam int QW   = 34;
  localparam int FRAC = 30;
  typedef logic signed [QW-1:0] q_t;

  // Square root operand and result word
  localparam int SQW = 63;
  typedef logic [SQW-1:0] sqv_t;

  localparam int SQRT_STEPS = 32;
  localparam int DIV_STEPS  = 31;
  // Input register, squares, setup, root stages, divide setup, divide
  // stages, then frame, cross product, difference, blend and output.
  localparam int LATENCY = 3 + SQRT_STEPS + 1 + DIV_STEPS + 5;

  localparam logic [32:0] TWO_PI_Q      = 33'd6746518852;
  localparam q_t          CORDIC_GAIN_Q = 34'sd652032874;

  // Quadrant codes from the top two bits of the turn
  localparam logic [1:0] QUAD_I   = 2'd0;
  localparam logic [1:0] QUAD_II  = 2'd1;
  localparam logic [1:0] QUAD_III = 2'd2;

  // Arctangent of 2^-step in Q.30
  function automatic logic [29:0] atan_q(input int step);
    logic [29:0] v;
    case (step)
      0:  v = 30'd843314857;
      1:  v = 30'd497837829;
      2:  v = 30'd263043837;
      3:  v = 30'd133525159;
      4:  v = 30'd67021687;
      5:  v = 30'd33543516;
      6:  v = 30'd16775851;
      7:  v = 30'd8388437;
      8:  v = 30'd4194283;
      9:  v = 30'd2097149;
      10: v = 30'd1048576;
      11: v = 30'd524288;
      12: v = 30'd262144;
      13: v = 30'd131072;
      14: v = 30'd65536;
      15: v = 30'd32768;
      16: v = 30'd16384;
      17: v = 30'd8192;
      18: v = 30'd4096;
      19: v = 30'd2048;
      20: v = 30'd1024;
      21: v = 30'd512;
      22: v = 30'd256;
      23: v = 30'd128;
      24: v = 30'd64;
      25: v = 30'd32;
      26: v = 30'd16;
      27: v = 30'd8;
      28: v = 30'd4;
      29: v = 30'd2;
      30: v = 30'd1;
      default: v = 30'd0;
    endcase
    return v;
  endfunction

endpackage

`default_nettype wire

// ===== src/hemisphere_direction_sampler_unit.sv =====
// ---------------------------------------------------------------------------
// Hemisphere direction sampler
// Uniform hemisphere sample around a normal, rotated into a tangent frame.
// ---------------------------------------------------------------------------
// Usage:
//   Command channel: raise start with rand_a, rand_b and normal_x/y/z; the
//   transaction is taken at the rising edge where start is high and busy is
//   low. busy is high only while rst is held, so one transaction can be
//   taken in every cycle.
//   Result channel: done strobes for one cycle with dir_x/y/z and
//   degenerate. The receiver cannot hold results off; every result must be
//   captured in its done cycle.
//   The latency from the accepting edge to the edge that ends the done cycle
//   is hds_pkg::LATENCY; throughput is one transaction per cycle.
//   The depth is set by the two bit-per-stage square roots (32 stages, with
//   the sine/cosine rotation running alongside them) and the bit-per-stage
//   restoring divider for the tangent (31 stages).
//   Reset drops every transaction in flight; no result leaves for them.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module hemisphere_direction_sampler_unit #(
  parameter int DATA_BITS    = 16,
  parameter int CORDIC_STEPS = 16
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  output logic                        busy,
  input  logic        [DATA_BITS-1:0] rand_a,
  input  logic        [DATA_BITS-1:0] rand_b,
  input  logic signed [DATA_BITS-1:0] normal_x,
  input  logic signed [DATA_BITS-1:0] normal_y,
  input  logic signed [DATA_BITS-1:0] normal_z,
  output logic                        done,
  output logic signed [DATA_BITS-1:0] dir_x,
  output logic signed [DATA_BITS-1:0] dir_y,
  output logic signed [DATA_BITS-1:0] dir_z,
  output logic                        degenerate
);

  localparam int QW   = hds_pkg::QW;
  localparam int FRAC = hds_pkg::FRAC;

  // Scaling between field format and Q.30: one of the two is zero
  localparam int SH_UP = (DATA_BITS <= 31) ? (31 - DATA_BITS) : 0;
  localparam int SH_DN = (DATA_BITS > 31) ? (DATA_BITS - 31) : 0;

  typedef logic signed [QW+1:0] ow_t;
  localparam ow_t OUT_HI = ow_t'((longint'(1) <<< (DATA_BITS - 1)) - 1);
  localparam ow_t OUT_LO = ow_t'(-(longint'(1) <<< (DATA_BITS - 1)));

  // Values that ride along the whole pipe
  typedef struct packed {
    logic [30:0]   lz;
    hds_pkg::q_t   nx;
    hds_pkg::q_t   ny;
    hds_pkg::q_t   nz;
    logic          sel;
  } carry_t;

  typedef struct packed {
    logic          valid;
    logic [30:0]   lz;
    hds_pkg::q_t   ang;
    logic [1:0]    quad;
    hds_pkg::q_t   nx;
    hds_pkg::q_t   ny;
    hds_pkg::q_t   nz;
  } s1_t;

  typedef struct packed {
    logic          valid;
    carry_t        c;
    hds_pkg::q_t   ang;
    logic [1:0]    quad;
    logic [61:0]   lzsq;
    logic [60:0]   sqx;
    logic [60:0]   sqy;
    logic [60:0]   sqz;
  } s2_t;

  // Root stage: radius root (a), frame length root (b), rotation x/y/angle
  typedef struct packed {
    logic          valid;
    carry_t        c;
    logic [1:0]    quad;
    hds_pkg::sqv_t va;
    hds_pkg::sqv_t ra;
    hds_pkg::sqv_t vb;
    hds_pkg::sqv_t rb;
    hds_pkg::q_t   cx;
    hds_pkg::q_t   cy;
    hds_pkg::q_t   ca;
  } root_t;

  typedef struct packed {
    logic          valid;
    carry_t        c;
    logic          deg;
    logic [31:0]   len;
    logic [60:0]   rem1;
    logic [60:0]   rem2;
    logic [30:0]   q1;
    logic [30:0]   q2;
    logic          neg1;
    logic          neg2;
    logic [30:0]   r;
    hds_pkg::q_t   cs;
    hds_pkg::q_t   sn;
    hds_pkg::q_t   lx;
    hds_pkg::q_t   ly;
  } div_t;

  typedef struct packed {
    logic          valid;
    carry_t        c;
    logic          deg;
    hds_pkg::q_t   lx;
    hds_pkg::q_t   ly;
    hds_pkg::q_t   cx;
    hds_pkg::q_t   cy;
    hds_pkg::q_t   cz;
  } frame_t;

  typedef struct packed {
    logic          valid;
    carry_t        c;
    logic          deg;
    hds_pkg::q_t   lx;
    hds_pkg::q_t   ly;
    hds_pkg::q_t   cx;
    hds_pkg::q_t   cy;
    hds_pkg::q_t   cz;
    hds_pkg::q_t   m0;
    hds_pkg::q_t   m1;
    hds_pkg::q_t   m2;
    hds_pkg::q_t   m3;
    hds_pkg::q_t   m4;
    hds_pkg::q_t   m5;
  } cross_t;

  typedef struct packed {
    logic          valid;
    carry_t        c;
    logic          deg;
    hds_pkg::q_t   lx;
    hds_pkg::q_t   ly;
    hds_pkg::q_t   cx;
    hds_pkg::q_t   cy;
    hds_pkg::q_t   cz;
    hds_pkg::q_t   bx;
    hds_pkg::q_t   by;
    hds_pkg::q_t   bz;
  } basis_t;

  typedef struct packed {
    logic          valid;
    logic          deg;
    hds_pkg::q_t   xb;
    hds_pkg::q_t   xc;
    hds_pkg::q_t   xn;
    hds_pkg::q_t   yb;
    hds_pkg::q_t   yc;
    hds_pkg::q_t   yn;
    hds_pkg::q_t   zb;
    hds_pkg::q_t   zc;
    hds_pkg::q_t   zn;
  } blend_t;

  // ---------------------------------------------------------------------
  // Arithmetic helpers
  // ---------------------------------------------------------------------
  function automatic hds_pkg::q_t to_q(input logic signed [DATA_BITS-1:0] v);
    hds_pkg::q_t w;
    w = hds_pkg::q_t'(v);
    return (w <<< SH_UP) >>> SH_DN;
  endfunction

  // Q.30 product, floored
  function automatic hds_pkg::q_t qmul(input hds_pkg::q_t a, input hds_pkg::q_t b);
    logic signed [2*QW-1:0] p;
    p = a * b;
    return hds_pkg::q_t'(p >>> FRAC);
  endfunction

  function automatic hds_pkg::q_t absq(input hds_pkg::q_t v);
    return v[QW-1] ? -v : v;
  endfunction

  function automatic logic [60:0] square(input hds_pkg::q_t v);
    logic signed [2*QW-1:0] p;
    p = v * v;
    return p[60:0];
  endfunction

  // Q.30 back to the field format, saturated
  function automatic logic signed [DATA_BITS-1:0] sat_out(input hds_pkg::q_t s);
    ow_t v;
    v = (ow_t'(s) >>> SH_UP) <<< SH_DN;
    if (v > OUT_HI) begin
      v = OUT_HI;
    end else if (v < OUT_LO) begin
      v = OUT_LO;
    end
    return DATA_BITS'(v);
  endfunction

  // No backpressure inside: only reset holds off commands
  assign busy = rst;

  // ---------------------------------------------------------------------
  // Stage 1: polar height, azimuth angle, normal in Q.30
  // ---------------------------------------------------------------------
  s1_t              s1;
  s1_t              s1_next;
  logic [29:0]      ua;
  logic [29:0]      ub;
  logic signed [31:0] h;
  logic [60:0]      angp;

  always_comb begin
    ua   = 30'(({rand_a, 30'b0}) >> DATA_BITS);
    ub   = 30'(({rand_b, 30'b0}) >> DATA_BITS);
    h    = 32'sh4000_0000 - $signed({1'b0, ua, 1'b0});
    angp = 61'(ub[27:0]) * 61'(hds_pkg::TWO_PI_Q);
    s1_next.valid = start && !busy;
    s1_next.lz    = h[31] ? 31'(-h) : 31'(h);
    s1_next.ang   = hds_pkg::q_t'({1'b0, angp[60:30]});
    s1_next.quad  = ub[29:28];
    s1_next.nx    = to_q(normal_x);
    s1_next.ny    = to_q(normal_y);
    s1_next.nz    = to_q(normal_z);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1.valid <= 1'b0;
    end else begin
      s1 <= s1_next;
    end
  end

  // ---------------------------------------------------------------------
  // Stage 2: squares and choice of tangent pair
  // ---------------------------------------------------------------------
  s2_t s2;
  s2_t s2_next;

  always_comb begin
    s2_next.valid = s1.valid;
    s2_next.c.lz  = s1.lz;
    s2_next.c.nx  = s1.nx;
    s2_next.c.ny  = s1.ny;
    s2_next.c.nz  = s1.nz;
    // A tie in magnitude takes the y,z pair
    s2_next.c.sel = absq(s1.nx) > absq(s1.ny);
    s2_next.ang   = s1.ang;
    s2_next.quad  = s1.quad;
    s2_next.lzsq  = 62'(s1.lz) * 62'(s1.lz);
    s2_next.sqx   = square(s1.nx);
    s2_next.sqy   = square(s1.ny);
    s2_next.sqz   = square(s1.nz);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s2.valid <= 1'b0;
    end else begin
      s2 <= s2_next;
    end
  end

  // ---------------------------------------------------------------------
  // Stage 3: root operands and rotation start
  // ---------------------------------------------------------------------
  root_t       root [0:hds_pkg::SQRT_STEPS];
  root_t       root_first;
  logic [30:0] tr;

  always_comb begin
    tr = 31'(33'h0_4000_0000 - 33'(s2.lzsq[61:30]));
    root_first.valid = s2.valid;
    root_first.c     = s2.c;
    root_first.quad  = s2.quad;
    root_first.va    = hds_pkg::sqv_t'({tr, 30'b0});
    root_first.ra    = '0;
    root_first.vb    = hds_pkg::sqv_t'(s2.c.sel ? s2.sqx : s2.sqy) + hds_pkg::sqv_t'(s2.sqz);
    root_first.rb    = '0;
    root_first.cx    = hds_pkg::CORDIC_GAIN_Q;
    root_first.cy    = '0;
    root_first.ca    = s2.ang;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      root[0].valid <= 1'b0;
    end else begin
      root[0] <= root_first;
    end
  end

  // ---------------------------------------------------------------------
  // Root stages: one result bit of each root per stage; rotation steps
  // share the first CORDIC_STEPS of these stages.
  // ---------------------------------------------------------------------
  for (genvar k = 0; k < hds_pkg::SQRT_STEPS; k++) begin : g_root
    localparam hds_pkg::sqv_t BIT = hds_pkg::sqv_t'(1) << (62 - 2 * k);
    localparam hds_pkg::q_t ATAN = hds_pkg::q_t'(hds_pkg::atan_q(k));
    root_t nxt;

    always_comb begin
      nxt = root[k];
      if (root[k].va >= root[k].ra + BIT) begin
        nxt.va = root[k].va - (root[k].ra + BIT);
        nxt.ra = (root[k].ra >> 1) + BIT;
      end else begin
        nxt.ra = root[k].ra >> 1;
      end
      if (root[k].vb >= root[k].rb + BIT) begin
        nxt.vb = root[k].vb - (root[k].rb + BIT);
        nxt.rb = (root[k].rb >> 1) + BIT;
      end else begin
        nxt.rb = root[k].rb >> 1;
      end
      if (k < CORDIC_STEPS) begin
        if (!root[k].ca[QW-1]) begin
          nxt.cx = root[k].cx - (root[k].cy >>> k);
          nxt.cy = root[k].cy + (root[k].cx >>> k);
          nxt.ca = root[k].ca - ATAN;
        end else begin
          nxt.cx = root[k].cx + (root[k].cy >>> k);
          nxt.cy = root[k].cy - (root[k].cx >>> k);
          nxt.ca = root[k].ca + ATAN;
        end
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        root[k+1].valid <= 1'b0;
      end else begin
        root[k+1] <= nxt;
      end
    end
  end

  // ---------------------------------------------------------------------
  // Divide setup: quadrant fold, zero-length check, tangent dividends
  // ---------------------------------------------------------------------
  div_t        dv [0:hds_pkg::DIV_STEPS];
  div_t        dv_first;
  root_t       re;
  hds_pkg::q_t az;
  hds_pkg::q_t pick;
  hds_pkg::q_t ap;

  always_comb begin
    re   = root[hds_pkg::SQRT_STEPS];
    pick = re.c.sel ? re.c.nx : re.c.ny;
    az   = absq(re.c.nz);
    ap   = absq(pick);
    dv_first.valid = re.valid;
    dv_first.c     = re.c;
    case (re.quad)
      hds_pkg::QUAD_I: begin
        dv_first.cs = re.cx;
        dv_first.sn = re.cy;
      end
      hds_pkg::QUAD_II: begin
        dv_first.cs = -re.cy;
        dv_first.sn = re.cx;
      end
      hds_pkg::QUAD_III: begin
        dv_first.cs = -re.cx;
        dv_first.sn = -re.cy;
      end
      default: begin
        dv_first.cs = re.cy;
        dv_first.sn = -re.cx;
      end
    endcase
    dv_first.r    = re.ra[30:0];
    dv_first.len  = re.rb[31:0];
    dv_first.deg  = (re.rb == '0);
    dv_first.rem1 = {az[30:0], 30'b0};
    dv_first.rem2 = {ap[30:0], 30'b0};
    dv_first.q1   = '0;
    dv_first.q2   = '0;
    // Quotient signs: nz/len and -pick/len
    dv_first.neg1 = re.c.nz[QW-1];
    dv_first.neg2 = !pick[QW-1];
    dv_first.lx   = '0;
    dv_first.ly   = '0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dv[0].valid <= 1'b0;
    end else begin
      dv[0] <= dv_first;
    end
  end

  // ---------------------------------------------------------------------
  // Divide stages: one quotient bit of both tangent terms per stage
  // ---------------------------------------------------------------------
  for (genvar j = 0; j < hds_pkg::DIV_STEPS; j++) begin : g_div
    localparam int B = hds_pkg::DIV_STEPS - 1 - j;
    div_t        nxt;
    logic [61:0] d;

    always_comb begin
      nxt = dv[j];
      d   = 62'(dv[j].len) << B;
      if ({1'b0, dv[j].rem1} >= d) begin
        nxt.rem1   = dv[j].rem1 - d[60:0];
        nxt.q1[B]  = 1'b1;
      end
      if ({1'b0, dv[j].rem2} >= d) begin
        nxt.rem2   = dv[j].rem2 - d[60:0];
        nxt.q2[B]  = 1'b1;
      end
      // Local x and y ride in the first divide stage
      if (j == 0) begin
        nxt.lx = qmul(hds_pkg::q_t'({1'b0, dv[j].r}), dv[j].cs);
        nxt.ly = qmul(hds_pkg::q_t'({1'b0, dv[j].r}), dv[j].sn);
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        dv[j+1].valid <= 1'b0;
      end else begin
        dv[j+1] <= nxt;
      end
    end
  end

  // ---------------------------------------------------------------------
  // Frame: signed tangent C
  // ---------------------------------------------------------------------
  frame_t      fr;
  frame_t      fr_next;
  div_t        de;
  hds_pkg::q_t q1s;
  hds_pkg::q_t q2s;

  always_comb begin
    de  = dv[hds_pkg::DIV_STEPS];
    q1s = de.neg1 ? -hds_pkg::q_t'(de.q1) : hds_pkg::q_t'(de.q1);
    q2s = de.neg2 ? -hds_pkg::q_t'(de.q2) : hds_pkg::q_t'(de.q2);
    fr_next.valid = de.valid;
    fr_next.c     = de.c;
    fr_next.deg   = de.deg;
    fr_next.lx    = de.lx;
    fr_next.ly    = de.ly;
    fr_next.cx    = de.c.sel ? q1s : '0;
    fr_next.cy    = de.c.sel ? '0 : q1s;
    fr_next.cz    = q2s;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fr.valid <= 1'b0;
    end else begin
      fr <= fr_next;
    end
  end

  // ---------------------------------------------------------------------
  // Cross product terms of B = C x N
  // ---------------------------------------------------------------------
  cross_t cr;
  cross_t cr_next;

  always_comb begin
    cr_next.valid = fr.valid;
    cr_next.c     = fr.c;
    cr_next.deg   = fr.deg;
    cr_next.lx    = fr.lx;
    cr_next.ly    = fr.ly;
    cr_next.cx    = fr.cx;
    cr_next.cy    = fr.cy;
    cr_next.cz    = fr.cz;
    cr_next.m0    = qmul(fr.cy, fr.c.nz);
    cr_next.m1    = qmul(fr.cz, fr.c.ny);
    cr_next.m2    = qmul(fr.cz, fr.c.nx);
    cr_next.m3    = qmul(fr.cx, fr.c.nz);
    cr_next.m4    = qmul(fr.cx, fr.c.ny);
    cr_next.m5    = qmul(fr.cy, fr.c.nx);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cr.valid <= 1'b0;
    end else begin
      cr <= cr_next;
    end
  end

  // ---------------------------------------------------------------------
  // Bitangent B
  // ---------------------------------------------------------------------
  basis_t bs;
  basis_t bs_next;

  always_comb begin
    bs_next.valid = cr.valid;
    bs_next.c     = cr.c;
    bs_next.deg   = cr.deg;
    bs_next.lx    = cr.lx;
    bs_next.ly    = cr.ly;
    bs_next.cx    = cr.cx;
    bs_next.cy    = cr.cy;
    bs_next.cz    = cr.cz;
    bs_next.bx    = cr.m0 - cr.m1;
    bs_next.by    = cr.m2 - cr.m3;
    bs_next.bz    = cr.m4 - cr.m5;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      bs.valid <= 1'b0;
    end else begin
      bs <= bs_next;
    end
  end

  // ---------------------------------------------------------------------
  // Blend terms x*B, y*C, z*N per axis
  // ---------------------------------------------------------------------
  blend_t      bl;
  blend_t      bl_next;
  hds_pkg::q_t lzq;

  always_comb begin
    lzq = hds_pkg::q_t'({1'b0, bs.c.lz});
    bl_next.valid = bs.valid;
    bl_next.deg   = bs.deg;
    bl_next.xb    = qmul(bs.lx, bs.bx);
    bl_next.xc    = qmul(bs.ly, bs.cx);
    bl_next.xn    = qmul(lzq, bs.c.nx);
    bl_next.yb    = qmul(bs.lx, bs.by);
    bl_next.yc    = qmul(bs.ly, bs.cy);
    bl_next.yn    = qmul(lzq, bs.c.ny);
    bl_next.zb    = qmul(bs.lx, bs.bz);
    bl_next.zc    = qmul(bs.ly, bs.cz);
    bl_next.zn    = qmul(lzq, bs.c.nz);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      bl.valid <= 1'b0;
    end else begin
      bl <= bl_next;
    end
  end

  // ---------------------------------------------------------------------
  // Output register: sum, saturate, force zeros on a degenerate frame
  // ---------------------------------------------------------------------
  logic signed [DATA_BITS-1:0] dir_x_next;
  logic signed [DATA_BITS-1:0] dir_y_next;
  logic signed [DATA_BITS-1:0] dir_z_next;

  always_comb begin
    if (bl.deg) begin
      dir_x_next = '0;
      dir_y_next = '0;
      dir_z_next = '0;
    end else begin
      dir_x_next = sat_out(bl.xb + bl.xc + bl.xn);
      dir_y_next = sat_out(bl.yb + bl.yc + bl.yn);
      dir_z_next = sat_out(bl.zb + bl.zc + bl.zn);
    end
  end

  always_ff @(posedge clk) begin
    dir_x      <= dir_x_next;
    dir_y      <= dir_y_next;
    dir_z      <= dir_z_next;
    degenerate <= bl.deg;
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= bl.valid;
    end
  end

endmodule

`default_nettype wire

// ===== src/hds_checker.sv =====
// ---------------------------------------------------------------------------
// Hemisphere direction sampler checker
// Port-level timing and result checks, bound to the top level.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "hemisphere_direction_sampler_unit_defines.svh"

module hds_checker #(
  parameter int DATA_BITS = 16
) (
  input logic                        clk,
  input logic                        rst,
  input logic                        start,
  input logic                        busy,
  input logic                        done,
  input logic signed [DATA_BITS-1:0] dir_x,
  input logic signed [DATA_BITS-1:0] dir_y,
  input logic signed [DATA_BITS-1:0] dir_z,
  input logic                        degenerate
);

  // Every result traces back to a transaction a fixed latency earlier
  `HDS_ASSERT_IMPLY(a_done_has_cmd, done, $past(start && !busy, hds_pkg::LATENCY))

  // Every transaction yields its result after the fixed latency
  `HDS_ASSERT_IMPLY(a_cmd_gives_done, start && !busy, ##(hds_pkg::LATENCY) done)

  // A degenerate frame drives zeros
  `HDS_ASSERT_IMPLY(a_degenerate_zero, done && degenerate, dir_x == 0 && dir_y == 0 && dir_z == 0)

  // Reset empties the pipe
  `HDS_ASSERT_NEXT(a_reset_clears, $past(rst) && rst, !done)

endmodule

bind hemisphere_direction_sampler_unit hds_checker #(.DATA_BITS(DATA_BITS)) u_hds_checker (
  .clk       (clk),
  .rst       (rst),
  .start     (start),
  .busy      (busy),
  .done      (done),
  .dir_x     (dir_x),
  .dir_y     (dir_y),
  .dir_z     (dir_z),
  .degenerate(degenerate)
);

`default_nettype wire
